// File: rtl/core/abelian_square_suffix_detector_top_defines.svh
// Assertion macros shared by the detector modules.
// Each macro expects a clock named clk and a reset named arst_n in scope.
`ifndef ABELIAN_SQUARE_SUFFIX_DETECTOR_TOP_DEFINES_SVH
`define ABELIAN_SQUARE_SUFFIX_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define ASD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/asd_pkg.sv
package asd_pkg;

	localparam int MAX_HALF_DEF = 40;
	localparam int LETTER_W     = 2;
	localparam int CFG_W        = 6;
	localparam int HALF_W       = 6;
	localparam int WLEN_W       = 7;
	// Letters a, b, c carry difference counters; the fourth code needs none
	// (see tracker).
	localparam int NUM_TRACKED  = 3;
	localparam logic [CFG_W-1:0] MAX_HALF_RST = 6'd40;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                new_word;
	} in_item_t;

	typedef struct packed {
		logic              square_found;
		logic [HALF_W-1:0] half_length;
		logic [WLEN_W-1:0] word_length;
	} out_item_t;

endpackage

// File: rtl/core/asd_tracker.sv
`include "abelian_square_suffix_detector_top_defines.svh"

module asd_tracker import asd_pkg::*; #(
	parameter int MAX_HALF = MAX_HALF_DEF,
	localparam int HD      = 2 * MAX_HALF,
	localparam int LEN_W   = $clog2(HD + 1),
	localparam int DW      = $clog2(MAX_HALF + 1) + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	input  logic                s1_take,
	output logic                valid_s1,
	output logic [MAX_HALF:2]   hit_s1,
	output logic [LEN_W-1:0]    len_s1
);

	logic [LETTER_W-1:0] hist_q [HD];
	logic [LEN_W-1:0]    len_q;
	// Per block length k and letter: count in newer half minus count in
	// older half, two's complement, DW bits.
	logic [DW-1:0]       diff_q [2:MAX_HALF][NUM_TRACKED];
	logic [DW-1:0]       diff_d [2:MAX_HALF][NUM_TRACKED];
	logic [MAX_HALF:2]   hit_d;
	logic [LEN_W-1:0]    len_old;
	logic [LEN_W-1:0]    len_new;
	logic                accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1 || s1_take;

	assign len_old = in_data.new_word ? '0 : len_q;
	assign len_new = (len_old < LEN_W'(HD)) ? len_old + LEN_W'(1) : len_old;

	// Incremental update per k: the new letter enters the newer half,
	// old position k-1 crosses into the older half, old position 2k-1 drops
	// out. Positions beyond the current word do not count, so a fresh word
	// starts every counter from zero. The fourth letter code is only ever
	// compared with both halves full, where its difference is minus the sum
	// of the other three.
	always_comb begin
		logic [DW-1:0] base;
		logic          va;
		logic          vb;
		logic          all_zero;
		for (int k = 2; k <= MAX_HALF; k++) begin
			va       = LEN_W'(k - 1) < len_old;
			vb       = LEN_W'(2 * k - 1) < len_old;
			all_zero = 1'b1;
			for (int c = 0; c < NUM_TRACKED; c++) begin
				base = (len_old == '0) ? '0 : diff_q[k][c];
				diff_d[k][c] = base
					+ DW'(in_data.letter == LETTER_W'(c))
					- DW'(2 * (va && hist_q[k - 1] == LETTER_W'(c)))
					+ DW'(vb && hist_q[2 * k - 1] == LETTER_W'(c));
				all_zero = all_zero && (diff_d[k][c] == '0);
			end
			hit_d[k] = all_zero && (len_new >= LEN_W'(2 * k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			len_q    <= len_new;
			valid_s1 <= 1'b1;
		end else if (s1_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_q[0] <= in_data.letter;
			for (int i = 1; i < HD; i++) begin
				hist_q[i] <= hist_q[i - 1];
			end
			diff_q <= diff_d;
			hit_s1 <= hit_d;
			len_s1 <= len_new;
		end
	end

	`ASD_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LEN_W'(HD), "length above history depth")
	`ASD_ASSERT_NEXT(a_len_fresh, accept && in_data.new_word, len_q == LEN_W'(1),
		"fresh word must restart length at one")
	`ASD_ASSERT_NEXT(a_len_step, accept && !in_data.new_word && len_q < LEN_W'(HD),
		len_q == $past(len_q) + LEN_W'(1), "length must grow by one per letter")

endmodule

// File: rtl/core/asd_select.sv
`include "abelian_square_suffix_detector_top_defines.svh"

module asd_select import asd_pkg::*; #(
	parameter int MAX_HALF = MAX_HALF_DEF,
	localparam int HD      = 2 * MAX_HALF,
	localparam int LEN_W   = $clog2(HD + 1),
	localparam int KW      = $clog2(MAX_HALF + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  max_half,
	input  logic              valid_s1,
	input  logic [MAX_HALF:2] hit_s1,
	input  logic [LEN_W-1:0]  len_s1,
	output logic              s1_take,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	logic [KW-1:0]           k_min;
	logic                    found;
	logic [KW+HALF_W-1:0]    k_ext;
	logic [LEN_W+WLEN_W-1:0] len_ext;
	out_item_t               res_d;

	assign s1_take = !out_valid || out_ready;

	// Smallest enabled k wins: scan downward so the last hit kept is lowest.
	always_comb begin
		k_min = '0;
		found = 1'b0;
		for (int k = MAX_HALF; k >= 2; k--) begin
			if (hit_s1[k] && k <= int'(max_half)) begin
				k_min = KW'(k);
				found = 1'b1;
			end
		end
	end

	assign k_ext   = {{HALF_W{1'b0}}, k_min};
	assign len_ext = {{WLEN_W{1'b0}}, len_s1};

	always_comb begin
		res_d.square_found = found;
		res_d.half_length  = k_ext[HALF_W-1:0];
		res_d.word_length  = len_ext[WLEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_take) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && valid_s1) begin
			out_data <= res_d;
		end
	end

	`ASD_ASSERT_NEXT(a_load_shows, s1_take && valid_s1, out_valid,
		"stage result not presented")
	`ASD_ASSERT_NOW(a_found_k, out_valid && !out_data.square_found,
		out_data.half_length == '0, "length reported without a square")

endmodule

// File: rtl/core/abelian_square_suffix_detector_top.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data  (in_item_t: letter, new_word)
// out      output     out_valid / out_ready  out_data (out_item_t: square_found,
//                                                      half_length, word_length)
// cfg      input      cfg_valid / cfg_ready  cfg_data (max_half, 6 bits)
//
// One letter per cycle while the output is not stalled; each transaction's result
// is registered in the tracker stage (s1 hit register), then in the output register.
// The per-k difference counters update in the accept cycle.
// Reset clears the word length, the configured maximum (to 40) and both
// valid flags; history and counters need no reset.
// A stalled output holds in place; input is still taken while s1 is empty.
// cfg_ready is always high.
module abelian_square_suffix_detector_top import asd_pkg::*; #(
	parameter int MAX_HALF = MAX_HALF_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int HD    = 2 * MAX_HALF;
	localparam int LEN_W = $clog2(HD + 1);

	logic [CFG_W-1:0]  max_half_q;
	logic              s1_take;
	logic              valid_s1;
	logic [MAX_HALF:2] hit_s1;
	logic [LEN_W-1:0]  len_s1;

	// Config register: the user must write it only while idle (the block does not enforce this), so no shadowing.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_half_q <= MAX_HALF_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_half_q <= cfg_data;
		end
	end

	// History shift line, word length and per-k difference counters;
	// registers which block lengths close an abelian square.
	asd_tracker #(
		.MAX_HALF (MAX_HALF)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.s1_take  (s1_take),
		.valid_s1 (valid_s1),
		.hit_s1   (hit_s1),
		.len_s1   (len_s1)
	);

	// Applies the configured limit, picks the smallest k, holds the result.
	asd_select #(
		.MAX_HALF (MAX_HALF)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_half  (max_half_q),
		.valid_s1  (valid_s1),
		.hit_s1    (hit_s1),
		.len_s1    (len_s1),
		.s1_take   (s1_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
